>>> rtl/s2ns_pkg.sv
package s2ns_pkg;

    localparam int unsigned F64_W     = 64;
    localparam int unsigned EXP_W     = 11;
    localparam int unsigned FRAC_W    = 52;
    localparam int unsigned MANT_W    = 53;
    localparam int unsigned SCALE_W   = 30;
    localparam int unsigned PROD_W    = MANT_W + SCALE_W;
    localparam int unsigned K_W       = 12;

    localparam logic [SCALE_W-1:0] NS_PER_S  = 30'd1000000000;
    localparam logic [EXP_W-1:0]   EXP_MAX   = 11'h7FF;
    localparam logic [K_W-1:0]     EXP_BIAS  = 12'd1075;
    localparam logic [K_W-1:0]     K_SAT     = 12'd11;
    localparam logic [K_W-1:0]     K_NEG_MIN = 12'hFCB; // -53

    localparam logic [F64_W-1:0]   INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [F64_W-1:0]   INT64_MIN = 64'h8000_0000_0000_0000;

    // value class carried down the pipe
    typedef enum logic [1:0] {
        CLS_NUM,
        CLS_ZERO,
        CLS_SAT
    } s2ns_cls_t;

endpackage

>>> rtl/s2ns_in_if.sv
interface s2ns_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] seconds_bits;

    modport source (output valid, output seconds_bits, input ready);
    modport sink   (input valid, input seconds_bits, output ready);
endinterface

>>> rtl/s2ns_out_if.sv
interface s2ns_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] nanoseconds;

    modport source (output valid, output nanoseconds, input ready);
    modport sink   (input valid, input nanoseconds, output ready);
endinterface

>>> rtl/seconds_to_nanoseconds_saturating_top.sv
// Channel   | Dir | Beat payload
// ----------+-----+-------------------------------------------------
// seconds   | in  | seconds_bits : binary64 pattern, seconds
// nanos     | out | nanoseconds  : signed 64-bit count, saturated
//
// Six register stages; one beat may enter each cycle unless all are full and stalled.
// Stage depth is set by the split 53x30 mantissa multiply and the 83-bit
// product add; rounding, alignment shift and sign fix-up follow.
// rst_n (async, active low) clears the valid bits only.
// Each stage holds while the next is full and stalled; bubbles close up,
// so a stalled output still lets earlier stages fill.
module seconds_to_nanoseconds_saturating_top (
    input  logic         clk,
    input  logic         rst_n,
    s2ns_in_if.sink      seconds,
    s2ns_out_if.source   nanos
);
    import s2ns_pkg::*;

    // ---------------- per-stage valid and ready ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic r1, r2, r3, r4, r5, r6;

    assign r6 = !v6_reg || nanos.ready;
    assign r5 = !v5_reg || r6;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;

    assign seconds.ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= seconds.valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
            if (r6) v6_reg <= v5_reg;
        end
    end

    // ---------------- stage 1: unpack, split multiply ----------------
    // Subnormals and zeros scale to far below one half, so they go to zero.
    // Infinity saturates, NaN gives zero.
    logic [EXP_W-1:0]   in_exp;
    logic [FRAC_W-1:0]  in_frac;
    logic [MANT_W-1:0]  in_mant;
    s2ns_cls_t          cls1_next;

    assign in_exp  = seconds.seconds_bits[62:52];
    assign in_frac = seconds.seconds_bits[51:0];
    assign in_mant = {1'b1, in_frac};

    always_comb
    begin
        if (in_exp == '0)
            cls1_next = CLS_ZERO;
        else if (in_exp == EXP_MAX)
            cls1_next = (in_frac == '0) ? CLS_SAT : CLS_ZERO;
        else
            cls1_next = CLS_NUM;
    end

    logic               sign1_reg;
    s2ns_cls_t          cls1_reg;
    logic [EXP_W-1:0]   exp1_reg;
    logic [61:0]        plo1_reg;
    logic [50:0]        phi1_reg;

    always_ff @(posedge clk)
    begin
        if (r1 && seconds.valid)
        begin
            sign1_reg <= seconds.seconds_bits[63];
            cls1_reg  <= cls1_next;
            exp1_reg  <= in_exp;
            plo1_reg  <= 62'(in_mant[31:0]) * 62'(NS_PER_S);
            phi1_reg  <= 51'(in_mant[52:32]) * 51'(NS_PER_S);
        end
    end

    // ---------------- stage 2: product sum ----------------
    logic               sign2_reg;
    s2ns_cls_t          cls2_reg;
    logic [EXP_W-1:0]   exp2_reg;
    logic [PROD_W-1:0]  prod2_reg;

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            sign2_reg <= sign1_reg;
            cls2_reg  <= cls1_reg;
            exp2_reg  <= exp1_reg;
            prod2_reg <= {phi1_reg, 32'b0} + PROD_W'(plo1_reg);
        end
    end

    // ---------------- stage 3: round product to 53 bits, RNE ----------------
    // Product of two normalised mantissas has its top bit at 82 or 81.
    logic [MANT_W-1:0]  rm_mant;
    logic               rm_rnd, rm_sticky, rm_inc;
    logic [MANT_W:0]    rm_sum;
    logic [MANT_W-1:0]  mant3_next;
    logic [K_W-1:0]     k3_next;

    always_comb
    begin
        if (prod2_reg[82])
        begin
            rm_mant   = prod2_reg[82:30];
            rm_rnd    = prod2_reg[29];
            rm_sticky = |prod2_reg[28:0];
        end
        else
        begin
            rm_mant   = prod2_reg[81:29];
            rm_rnd    = prod2_reg[28];
            rm_sticky = |prod2_reg[27:0];
        end
        rm_inc     = rm_rnd && (rm_sticky || rm_mant[0]);
        rm_sum     = {1'b0, rm_mant} + (MANT_W+1)'(rm_inc);
        mant3_next = rm_sum[MANT_W] ? rm_sum[MANT_W:1] : rm_sum[MANT_W-1:0];
        // value = mant * 2^k
        k3_next    = {1'b0, exp2_reg} - EXP_BIAS
                   + (prod2_reg[82] ? 12'd30 : 12'd29)
                   + K_W'(rm_sum[MANT_W]);
    end

    logic               sign3_reg;
    s2ns_cls_t          cls3_reg;
    logic [MANT_W-1:0]  mant3_reg;
    logic [K_W-1:0]     k3_reg;

    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
        begin
            sign3_reg <= sign2_reg;
            cls3_reg  <= cls2_reg;
            mant3_reg <= mant3_next;
            k3_reg    <= k3_next;
        end
    end

    // ---------------- stage 4: range check and alignment ----------------
    logic               k_neg;
    logic               sat4_next;
    logic [F64_W-1:0]   q4_next;
    logic               half4_next;
    logic [5:0]         rsh;
    logic [MANT_W:0]    rsh_val;

    always_comb
    begin
        k_neg      = k3_reg[K_W-1];
        rsh        = 6'(-k3_reg);
        rsh_val    = {mant3_reg, 1'b0} >> rsh;
        sat4_next  = (cls3_reg == CLS_SAT) ||
                     ((cls3_reg == CLS_NUM) && !k_neg && (k3_reg >= K_SAT));
        q4_next    = '0;
        half4_next = 1'b0;
        if ((cls3_reg == CLS_NUM) && !sat4_next)
        begin
            if (!k_neg)
                q4_next = F64_W'(mant3_reg) << k3_reg[3:0];
            else if ($signed(k3_reg) >= $signed(K_NEG_MIN))
            begin
                q4_next    = F64_W'(rsh_val[MANT_W:1]);
                half4_next = rsh_val[0];
            end
        end
    end

    logic               sign4_reg;
    logic               sat4_reg;
    logic [F64_W-1:0]   q4_reg;
    logic               half4_reg;

    always_ff @(posedge clk)
    begin
        if (r4 && v3_reg)
        begin
            sign4_reg <= sign3_reg;
            sat4_reg  <= sat4_next;
            q4_reg    <= q4_next;
            half4_reg <= half4_next;
        end
    end

    // ---------------- stage 5: round half away from zero ----------------
    logic               sign5_reg;
    logic               sat5_reg;
    logic [F64_W-1:0]   mag5_reg;

    always_ff @(posedge clk)
    begin
        if (r5 && v4_reg)
        begin
            sign5_reg <= sign4_reg;
            sat5_reg  <= sat4_reg;
            mag5_reg  <= q4_reg + F64_W'(half4_reg);
        end
    end

    // ---------------- stage 6: sign and saturation, output register ----------------
    logic [F64_W-1:0]   res6_next;
    logic [F64_W-1:0]   res6_reg;

    always_comb
    begin
        if (sat5_reg)
            res6_next = sign5_reg ? INT64_MIN : INT64_MAX;
        else
            res6_next = sign5_reg ? (~mag5_reg + 64'd1) : mag5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (r6 && v5_reg)
            res6_reg <= res6_next;
    end

    assign nanos.valid       = v6_reg;
    assign nanos.nanoseconds = $signed(res6_reg);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned N_RANDOM    = 1230;
    localparam int unsigned DRAIN_AT    = 640;   // sender holds off here until all results are in

    logic clk;
    logic rst_n;

    s2ns_in_if  sec_ch ();
    s2ns_out_if ns_ch ();

    seconds_to_nanoseconds_saturating_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .seconds (sec_ch),
        .nanos   (ns_ch)
    );

    // Pending seconds patterns and expected nanosecond counts
    logic [63:0]        seconds_q[$];
    logic signed [63:0] nanos_expected_q[$];

    int unsigned n_sent;
    int unsigned n_errors;
    int unsigned quiet_cycles;
    int unsigned src_gap;
    int unsigned snk_gap;
    bit          src_busy;
    bit          drain_hold;
    bit          drain_done;
    bit          no_idle;

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n              = 1'b0;
        sec_ch.valid        = 1'b0;
        sec_ch.seconds_bits = '0;
        ns_ch.ready         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Scale binary64 seconds by 1e9 (IEEE double product, round to nearest even),
    // then saturate / zero NaN / round half away from zero.
    function automatic logic signed [63:0] seconds_to_ns(logic [63:0] secs_bits);
        real         scaled;
        logic [63:0] sb;
        logic [10:0] e;
        logic [63:0] mant;
        logic [63:0] mag;
        int          sh;
        if (secs_bits[62:52] == 11'h7FF && secs_bits[51:0] != '0)
            return '0;
        scaled = $bitstoreal(secs_bits) * 1.0e9;
        sb     = $realtobits(scaled);
        e      = sb[62:52];
        // infinities fall out of these two compares
        if (!sb[63] && e >= 11'd1086)
            return s2ns_pkg::INT64_MAX;
        if (sb[63] && e >= 11'd1086)
            return s2ns_pkg::INT64_MIN;
        if (e == '0)
            return '0;       // zero or subnormal: far below one half
        mant = {11'd0, 1'b1, sb[51:0]};
        sh   = 1075 - int'(e);
        if (sh <= 0)
            mag = mant << (-sh);
        else if (sh > 54)
            mag = '0;
        else
            mag = (mant + (64'd1 << (sh - 1))) >> sh;
        return sb[63] ? -$signed(mag) : $signed(mag);
    endfunction

    // Stimulus
    initial
    begin
        logic [63:0] b;
        real         v;
        int unsigned k;
        // signed zeros, subnormal extremes, smallest normal
        seconds_q.push_back(64'h0000_0000_0000_0000);
        seconds_q.push_back(64'h8000_0000_0000_0000);
        seconds_q.push_back(64'h0000_0000_0000_0001);
        seconds_q.push_back(64'h800F_FFFF_FFFF_FFFF);
        seconds_q.push_back(64'h0010_0000_0000_0000);
        // infinities, largest finite
        seconds_q.push_back(64'h7FF0_0000_0000_0000);
        seconds_q.push_back(64'hFFF0_0000_0000_0000);
        seconds_q.push_back(64'h7FEF_FFFF_FFFF_FFFF);
        seconds_q.push_back(64'hFFEF_FFFF_FFFF_FFFF);
        // quiet and signalling NaNs, both signs
        seconds_q.push_back(64'h7FF8_0000_0000_0000);
        seconds_q.push_back(64'hFFF0_0000_0000_0001);
        seconds_q.push_back(64'h7FF7_FFFF_FFFF_FFFF);
        seconds_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        // around 2^63 ns, both signs, one ulp either side
        b = $realtobits(9223372036.854775808);
        seconds_q.push_back(b - 1);
        seconds_q.push_back(b);
        seconds_q.push_back(b + 1);
        seconds_q.push_back({1'b1, b[62:0]} - 1);
        seconds_q.push_back({1'b1, b[62:0]});
        seconds_q.push_back({1'b1, b[62:0]} + 1);
        // exact halves: 2^-10 s = 976562.5 ns
        seconds_q.push_back($realtobits(0.0009765625));
        seconds_q.push_back($realtobits(-0.0009765625));
        seconds_q.push_back($realtobits(0.0029296875));
        seconds_q.push_back($realtobits(1.0));
        seconds_q.push_back($realtobits(-1.5e-9));
        seconds_q.push_back($realtobits(2.5e-9));

        for (k = 0; k < N_RANDOM; k++)
        begin
            case ($urandom_range(0, 3))
                0: b = {$urandom, $urandom};
                1:
                begin
                    // magnitude around the int64 range after scaling: mostly inside, top exponents past it
                    b = {$urandom, $urandom};
                    b[62:52] = 11'($urandom_range(1023 - 45, 1023 + 34));
                end
                2:
                begin
                    // multiples of 2^-10 s give exact results, half-nanosecond fractions for odd ones
                    v = real'($urandom_range(0, 2000000)) * 0.0009765625;
                    if ($urandom_range(0, 1))
                        v = -v;
                    b = $realtobits(v);
                end
                default:
                begin
                    // near saturation or near the rounding floor
                    b = {$urandom, $urandom};
                    b[62:52] = $urandom_range(0, 1) ? 11'($urandom_range(1053, 1056))
                                                    : 11'($urandom_range(990, 1000));
                end
            endcase
            seconds_q.push_back(b);
        end
    end

    // Source driver: changes on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!src_busy)
            begin
                if (n_sent == DRAIN_AT && !drain_done)
                    drain_hold = 1'b1;
                if (drain_hold && nanos_expected_q.size() == 0)
                begin
                    drain_hold = 1'b0;
                    drain_done = 1'b1;
                end
                if (src_gap > 0)
                begin
                    src_gap--;
                    sec_ch.valid <= 1'b0;
                end
                else if (!drain_hold && seconds_q.size() > 0)
                begin
                    sec_ch.seconds_bits <= seconds_q.pop_front();
                    sec_ch.valid        <= 1'b1;
                    src_busy = 1'b1;
                    src_gap  = pick_gap();
                end
                else
                    sec_ch.valid <= 1'b0;
            end

            // sink back-pressure
            if (snk_gap > 0)
            begin
                snk_gap--;
                ns_ch.ready <= 1'b0;
            end
            else
            begin
                ns_ch.ready <= 1'b1;
                snk_gap = pick_gap();
            end
        end
    end

    // Monitor: samples on the rising edge
    always @(posedge clk)
    begin
        logic signed [63:0] want;
        if (rst_n)
        begin
            quiet_cycles++;
            if (sec_ch.valid && sec_ch.ready)
            begin
                nanos_expected_q.push_back(seconds_to_ns(sec_ch.seconds_bits));
                src_busy = 1'b0;
                n_sent++;
                no_idle = ((n_sent / 200) % 3) == 1;   // idle-free stretches
                quiet_cycles = 0;
            end
            if (ns_ch.valid && ns_ch.ready)
            begin
                quiet_cycles = 0;
                if (nanos_expected_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected beat: nanoseconds=%0d", ns_ch.nanoseconds);
                end
                else
                begin
                    want = nanos_expected_q.pop_front();
                    if (ns_ch.nanoseconds !== want)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("nanoseconds mismatch: exp %0d (%h) got %0d (%h)",
                                     want, want, ns_ch.nanoseconds, ns_ch.nanoseconds);
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // End of run
    initial
    begin
        n_sent     = 0;
        n_errors   = 0;
        quiet_cycles = 0;
        src_gap    = 0;
        snk_gap    = 0;
        src_busy   = 1'b0;
        drain_hold = 1'b0;
        drain_done = 1'b0;
        no_idle    = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        wait (seconds_q.size() == 0 && !src_busy && nanos_expected_q.size() == 0);
        repeat (20) @(posedge clk);
        if (n_errors == 0 && nanos_expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
